FILE: sv/kvt_pkg.sv
// Package for the key/value table: shared widths, opcodes, status codes
// and the command and status structs between controller and datapath.
// No dependencies.
package kvt_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned ValW        = 32;
  localparam int unsigned CountW      = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_UPDATED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } kvt_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic out_ok;
  } kvt_sts_t;

endpackage

FILE: sv/kvt_if.sv
// Valid/ready channel interfaces for table requests and responses.
// Depends on kvt_pkg for field widths.
interface kvt_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic signed [kvt_pkg::KeyW-1:0]   key;
  logic [kvt_pkg::ValW-1:0]          value_in;

  modport source (output valid, output opcode, output key, output value_in, input ready);
  modport sink   (input valid, input opcode, input key, input value_in, output ready);
endinterface

interface kvt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [kvt_pkg::ValW-1:0]          value_out;
  logic [1:0]                        status;
  logic [kvt_pkg::CountW-1:0]        entry_count;

  modport source (output valid, output found, output value_out, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input value_out, input status,
                  input entry_count, output ready);
endinterface

FILE: sv/key_value_table_unit.sv
// Fully associative key/value table of CAPACITY slots holding unique 32-bit
// keys with 32-bit raw values; insert/update, lookup and remove, one result
// per request carrying the entry count. Slots are searched one per cycle
// from the key and value memories; a hit in a slot ends the search, while
// misses and new-key inserts read the whole table. New keys fill the
// lowest free slot. The result sits in an output register, so the next
// request can be accepted and searched while a response is pending, but
// it is not committed until that pending response is taken.
// Depends on kvt_pkg, kvt_if, kvt_ctrl and kvt_dpath.
module key_value_table_unit #(
  parameter int unsigned CAPACITY = kvt_pkg::CapacityDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kvt_req_if.sink    req_i,
  kvt_rsp_if.source  rsp_o
);
  import kvt_pkg::*;

  kvt_cmd_t cmd;
  kvt_sts_t sts;

  kvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  kvt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (req_i.opcode),
    .key_i         (req_i.key),
    .value_in_i    (req_i.value_in),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .found_o       (rsp_o.found),
    .value_out_o   (rsp_o.value_out),
    .status_o      (rsp_o.status),
    .entry_count_o (rsp_o.entry_count)
  );

`ifndef SYNTHESIS
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_FULL) |-> (rsp_o.entry_count == CountW'(CAPACITY)))
    else $error("table full reported below capacity");

  a_found_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.found) |-> (rsp_o.status == ST_DONE || rsp_o.status == ST_UPDATED))
    else $error("hit reported with miss status");

  a_value_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.value_out != '0) |-> (rsp_o.found && rsp_o.status == ST_DONE))
    else $error("value returned without lookup hit");

  a_single_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken during search");
`endif

endmodule

FILE: sv/kvt_dpath.sv
// Datapath of the key/value table: slot memories, valid bits, occupancy,
// the one-slot-per-cycle search pipeline and the result register.
// Depends on kvt_pkg.
module kvt_dpath #(
  parameter int unsigned CAPACITY = kvt_pkg::CapacityDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kvt_pkg::kvt_cmd_t          cmd_i,
  output kvt_pkg::kvt_sts_t          sts_o,
  input  logic [1:0]                 opcode_i,
  input  logic [kvt_pkg::KeyW-1:0]   key_i,
  input  logic [kvt_pkg::ValW-1:0]   value_in_i,
  input  logic                       rsp_ready_i,
  output logic                       rsp_valid_o,
  output logic                       found_o,
  output logic [kvt_pkg::ValW-1:0]   value_out_o,
  output logic [1:0]                 status_o,
  output logic [kvt_pkg::CountW-1:0] entry_count_o
);
  import kvt_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned OccW = $clog2(CAPACITY + 1);

  logic [KeyW-1:0]     key_mem [CAPACITY];
  logic [ValW-1:0]     val_mem [CAPACITY];

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [OccW-1:0]     occ_q, occ_d;
  logic [IdxW-1:0]     rd_idx_q, cmp_idx_q;
  logic                cmp_vld_q;
  logic [KeyW-1:0]     key_rd_q;
  logic [ValW-1:0]     val_rd_q;
  logic [1:0]          op_q;
  logic [KeyW-1:0]     key_q;
  logic [ValW-1:0]     val_q;
  logic                hit_q, free_q;
  logic [IdxW-1:0]     hit_idx_q, free_idx_q;
  logic [ValW-1:0]     hit_val_q;

  logic                out_vld_q;
  logic                found_q, found_d;
  logic [ValW-1:0]     value_q, value_d;
  logic [1:0]          status_q;
  status_e             status_d;
  logic [CountW-1:0]   cnt_q;
  logic [31:0]         occ_ext;

  logic                cmp_match, cmp_free, cmp_last;
  logic                key_we, val_we;
  logic [IdxW-1:0]     wr_idx;

  assign cmp_match = cmp_vld_q && valid_q[cmp_idx_q] && (key_rd_q == key_q);
  assign cmp_free  = cmp_vld_q && !valid_q[cmp_idx_q];
  assign cmp_last  = cmp_vld_q && (cmp_idx_q == IdxW'(CAPACITY - 1));

  assign sts_o.hit    = cmp_match;
  assign sts_o.last   = cmp_last;
  assign sts_o.out_ok = !out_vld_q || rsp_ready_i;

  always_comb begin
    found_d  = 1'b0;
    value_d  = '0;
    status_d = ST_DONE;
    valid_d  = valid_q;
    occ_d    = occ_q;
    key_we   = 1'b0;
    val_we   = 1'b0;
    wr_idx   = hit_idx_q;
    if (cmd_i.commit) begin
      case (op_q)
        OP_INSERT: begin
          if (hit_q) begin
            val_we   = 1'b1;
            found_d  = 1'b1;
            status_d = ST_UPDATED;
          end else if (free_q) begin
            wr_idx              = free_idx_q;
            key_we              = 1'b1;
            val_we              = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            occ_d               = occ_q + 1'b1;
          end else begin
            status_d = ST_FULL;
          end
        end
        OP_LOOKUP: begin
          if (hit_q) begin
            found_d = 1'b1;
            value_d = hit_val_q;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        OP_REMOVE: begin
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
            if (occ_q != '0) begin
              occ_d = occ_q - 1'b1;
            end
            found_d = 1'b1;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign occ_ext = 32'(occ_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      occ_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      occ_q     <= occ_d;
      cmp_vld_q <= cmd_i.step;
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmp_match) begin
          hit_q <= 1'b1;
        end
        if (cmp_free) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      key_q    <= key_i;
      val_q    <= value_in_i;
      rd_idx_q <= '0;
    end else if (cmd_i.step) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end
    if (cmd_i.step) begin
      cmp_idx_q <= rd_idx_q;
    end
    if (cmp_match) begin
      hit_idx_q <= cmp_idx_q;
      hit_val_q <= val_rd_q;
    end
    if (cmp_free && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmd_i.commit) begin
      found_q  <= found_d;
      value_q  <= value_d;
      status_q <= status_d;
      cnt_q    <= occ_ext[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    if (cmd_i.step) begin
      key_rd_q <= key_mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_idx] <= val_q;
    end
    if (cmd_i.step) begin
      val_rd_q <= val_mem[rd_idx_q];
    end
  end

  assign rsp_valid_o   = out_vld_q;
  assign found_o       = found_q;
  assign value_out_o   = value_q;
  assign status_o      = status_q;
  assign entry_count_o = cnt_q;

endmodule

FILE: sv/kvt_ctrl.sv
// Controller of the key/value table: accept, slot search and commit.
// Depends on kvt_pkg for the command and status structs.
module kvt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output kvt_pkg::kvt_cmd_t cmd_o,
  input  kvt_pkg::kvt_sts_t sts_i
);
  import kvt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);
  assign cmd_o.load   = (state_q == S_IDLE) && req_valid_i;
  assign cmd_o.step   = (state_q == S_SCAN) && !sts_i.hit && !sts_i.last;
  assign cmd_o.commit = (state_q == S_COMMIT) && sts_i.out_ok;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.hit || sts_i.last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts_i.out_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
